### rtl/core/mh2_pkg.sv
// Shared constants, codes and types of the MurmurHash2 key hash block.
package mh2_pkg;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam logic [31:0] SEED_RESET = 32'd5381;
  localparam int          MIX_SHIFT  = 24;
  localparam int          FIN_SHIFT1 = 13;
  localparam int          FIN_SHIFT2 = 15;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // How a word is folded into the running hash.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FULL,
    KIND_TAIL
  } kind_t;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    kind_t       kind;
    logic        first;
    logic        last;
    logic [31:0] init_hash;
    logic [31:0] kval;
  } entry_t;

  typedef enum logic [1:0] {
    B_RUN,
    B_FIN,
    B_OUT
  } back_state_t;

endpackage

### rtl/core/mh2_front.sv
// Front end: accepts words, classifies them and premixes full words.
module mh2_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [71:0]          s_tdata,
  input  logic                 s_tuser,
  input  logic                 s_tlast,
  output logic                 push_valid,
  input  logic                 push_ready,
  output mh2_pkg::entry_t      push_entry
);

  logic [31:0]     seed;

  logic            s1_valid;
  mh2_pkg::kind_t  s1_kind;
  logic            s1_first;
  logic            s1_last;
  logic [31:0]     s1_init;
  logic [31:0]     s1_word;

  logic            s2_valid;
  mh2_pkg::kind_t  s2_kind;
  logic            s2_first;
  logic            s2_last;
  logic [31:0]     s2_init;
  logic [31:0]     s2_k;

  logic            adv;
  logic [31:0]     in_word;
  logic [2:0]      in_count;
  logic [30:0]     in_klen;
  mh2_pkg::kind_t  in_kind;
  logic [31:0]     in_masked;
  logic [31:0]     k1;
  logic [31:0]     k1_shx;
  logic [31:0]     k2;

  assign cfg_ready = 1'b1;

  assign in_word  = s_tdata[31:0];
  assign in_count = s_tdata[34:32];
  assign in_klen  = s_tdata[65:35];

  // The whole pipeline moves together; it holds only when the queue is full.
  assign adv      = !s2_valid || push_ready;
  assign s_tready = adv;

  always_comb begin
    in_kind   = mh2_pkg::KIND_NONE;
    in_masked = in_word;
    case (in_count)
      3'd0: begin
        in_kind   = mh2_pkg::KIND_NONE;
        in_masked = 32'd0;
      end
      3'd1: begin
        in_kind   = mh2_pkg::KIND_TAIL;
        in_masked = {24'd0, in_word[7:0]};
      end
      3'd2: begin
        in_kind   = mh2_pkg::KIND_TAIL;
        in_masked = {16'd0, in_word[15:0]};
      end
      3'd3: begin
        in_kind   = mh2_pkg::KIND_TAIL;
        in_masked = {8'd0, in_word[23:0]};
      end
      default: begin
        in_kind   = mh2_pkg::KIND_FULL;
        in_masked = in_word;
      end
    endcase
  end

  assign k1     = s1_word * mh2_pkg::MIX_MUL;
  assign k1_shx = s2_k ^ (s2_k >> mh2_pkg::MIX_SHIFT);
  assign k2     = k1_shx * mh2_pkg::MIX_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= mh2_pkg::SEED_RESET;
    end else if (cfg_valid) begin
      seed <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind  <= in_kind;
      s1_first <= s_tuser;
      s1_last  <= s_tlast;
      s1_init  <= seed ^ {1'b0, in_klen};
      s1_word  <= in_masked;
      s2_kind  <= s1_kind;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_init  <= s1_init;
      s2_k     <= (s1_kind == mh2_pkg::KIND_FULL) ? k1 : s1_word;
    end
  end

  always_comb begin
    push_valid           = s2_valid;
    push_entry.kind      = s2_kind;
    push_entry.first     = s2_first;
    push_entry.last      = s2_last;
    push_entry.init_hash = s2_init;
    push_entry.kval      = (s2_kind == mh2_pkg::KIND_FULL) ? k2 : s2_k;
  end

endmodule

### rtl/core/mh2_queue.sv
// Short register queue between the front end and the hash back end.
module mh2_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  mh2_pkg::entry_t  push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output mh2_pkg::entry_t  pop_entry
);

  mh2_pkg::entry_t                 slots [mh2_pkg::QUEUE_DEPTH];
  logic [mh2_pkg::QPTR_W-1:0]      wr_ptr;
  logic [mh2_pkg::QPTR_W-1:0]      rd_ptr;
  logic [mh2_pkg::QCNT_W-1:0]      count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count != mh2_pkg::QCNT_W'(mh2_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/mh2_back.sv
// Back end: folds words into the running hash, finalizes and holds the result.
module mh2_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  mh2_pkg::entry_t  pop_entry,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata
);

  mh2_pkg::back_state_t state;
  mh2_pkg::back_state_t state_next;

  logic [31:0] running_hash;
  logic [31:0] fin_prod;
  logic [31:0] h_base;
  logic [31:0] h_new;
  logic [31:0] fin_shx;
  logic [31:0] fin_mix;
  logic        fold;
  logic        load_out;

  always_comb begin
    h_base = pop_entry.first ? pop_entry.init_hash : running_hash;
    case (pop_entry.kind)
      mh2_pkg::KIND_FULL: h_new = (h_base * mh2_pkg::MIX_MUL) ^ pop_entry.kval;
      mh2_pkg::KIND_TAIL: h_new = (h_base ^ pop_entry.kval) * mh2_pkg::MIX_MUL;
      default:            h_new = h_base;
    endcase
  end

  assign fin_shx = running_hash ^ (running_hash >> mh2_pkg::FIN_SHIFT1);
  assign fin_mix = fin_shx * mh2_pkg::MIX_MUL;

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    fold       = 1'b0;
    load_out   = 1'b0;
    case (state)
      mh2_pkg::B_RUN: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          fold = 1'b1;
          if (pop_entry.last) begin
            state_next = mh2_pkg::B_FIN;
          end
        end
      end
      mh2_pkg::B_FIN: begin
        state_next = mh2_pkg::B_OUT;
      end
      mh2_pkg::B_OUT: begin
        // Wait until the output register is free or being emptied.
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = mh2_pkg::B_RUN;
        end
      end
      default: begin
        state_next = mh2_pkg::B_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mh2_pkg::B_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= 32'd0;
      m_tvalid     <= 1'b0;
    end else begin
      if (fold) begin
        running_hash <= h_new;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mh2_pkg::B_FIN) begin
      fin_prod <= fin_mix;
    end
    if (load_out) begin
      m_tdata <= fin_prod ^ (fin_prod >> mh2_pkg::FIN_SHIFT2);
    end
  end

endmodule

### rtl/core/murmur2_key_hash_top.sv
// Top level of the streaming 32-bit MurmurHash2 key hash.
//
//  channel  direction  bits of tdata / tuser / tlast
//  cfg      in         cfg_data[31:0] = seed
//  s        in         tdata: [31:0] data_word, [34:32] byte_count, [65:35] key_length;
//                      tuser = first_item; tlast = last_item
//  m        out        tdata: [31:0] hash_value
//
// A word that is not the last one does not hold the back end: the front end premixes full
// words through two registered multipliers and the back end folds one queued word per cycle
// while it is in its run state. A last word holds the back end for fold, finalize multiply
// and output load, in that order, before it takes the next queued word.
// Reset is synchronous and clears the pipeline, queue, running hash and output; the seed
// returns to 5381. A stalled output holds the back end, and a full queue stalls s_tready.
module murmur2_key_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // data_word, byte_count, key_length, zero pad
  input  logic        s_tuser,   // first_item
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // hash_value
);

  logic            push_valid;
  logic            push_ready;
  mh2_pkg::entry_t push_entry;
  logic            pop_valid;
  logic            pop_ready;
  mh2_pkg::entry_t pop_entry;

  mh2_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  mh2_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  mh2_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### rtl/core/mh2_checker.sv
// Port-level checks of the hash block and their binding to the top level.
module mh2_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // Reset empties the whole path, so input opens and no result is pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("block not empty after reset");

  // The seed register takes a word in any cycle.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration word refused");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind murmur2_key_hash_top mh2_checker u_mh2_checker (.*);
